### sv/ppsetup_pkg.sv
// shared types, constants and tables for the perspective projection setup block
package ppsetup_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int DIV_STEPS     = 32;
    localparam int DIV_LANES     = 4;

    localparam logic [15:0] FOV_MIN     = 16'd256;
    localparam logic [15:0] FOV_MAX     = 16'd45824;
    localparam logic [24:0] RAD_PER_DEG = 25'd18740330;

    localparam logic [15:0] FOV_RESET  = 16'd15360;
    localparam logic [31:0] NEAR_RESET = 32'd6554;
    localparam logic [31:0] FAR_RESET  = 32'd6553600;

    localparam logic [1:0] CFG_FOV  = 2'd0;
    localparam logic [1:0] CFG_NEAR = 2'd1;
    localparam logic [1:0] CFG_FAR  = 2'd2;

    localparam int LANE_XS = 0;
    localparam int LANE_YS = 1;
    localparam int LANE_DS = 2;
    localparam int LANE_DO = 3;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [23:0]        aspect;
    } t_cordic;

    typedef struct packed {
        logic [30:0] ux;
        logic [30:0] uy;
        logic [23:0] aspect;
        logic [54:0] p_auy;
        logic [54:0] p_aux;
        logic [63:0] p_fn;
    } t_mul;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] den;
        logic [31:0] nq;
        logic        ov;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [DIV_LANES-1:0] lane;
        logic                      err;
        logic                      fgt;
    } t_div_item;

endpackage

### sv/ppsetup_cordic_cell.sv
// one rotation cell of the tangent pipeline
module ppsetup_cordic_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_stage,
    input  logic               i_valid,
    input  ppsetup_pkg::t_cordic i_data,
    input  logic               i_ready,
    output logic               o_ready,
    output logic               o_valid,
    output ppsetup_pkg::t_cordic o_data
);
    import ppsetup_pkg::*;

    logic               r_valid;
    t_cordic            r_data;
    t_cordic            n_data;
    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [33:0] at;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        xr = i_data.x >>> i_stage;
        yr = i_data.y >>> i_stage;
        at = {2'b00, ATAN_Q30[i_stage]};
        n_data = i_data;
        if (!i_data.z[33]) begin
            n_data.x = i_data.x - yr;
            n_data.y = i_data.y + xr;
            n_data.z = i_data.z - at;
        end else begin
            n_data.x = i_data.x + yr;
            n_data.y = i_data.y - xr;
            n_data.z = i_data.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

### sv/ppsetup_div_cell.sv
// one quotient bit cell for the four parallel divisions
module ppsetup_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ppsetup_pkg::t_div_item i_data,
    input  logic                   i_ready,
    output logic                   o_ready,
    output logic                   o_valid,
    output ppsetup_pkg::t_div_item o_data
);
    import ppsetup_pkg::*;

    logic      r_valid;
    t_div_item r_data;
    t_div_item n_data;
    logic [64:0] r2 [DIV_LANES];
    logic        ge [DIV_LANES];
    logic [64:0] diff [DIV_LANES];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < DIV_LANES; k++) begin
            r2[k]   = {i_data.lane[k].rem, i_data.lane[k].nq[31]};
            ge[k]   = r2[k] >= {1'b0, i_data.lane[k].den};
            diff[k] = r2[k] - {1'b0, i_data.lane[k].den};
            n_data.lane[k].rem = ge[k] ? diff[k][63:0] : r2[k][63:0];
            n_data.lane[k].nq  = {i_data.lane[k].nq[30:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

### sv/perspective_projection_setup.sv
// perspective projection setup: top level with config registers and pipeline
// Takes one aspect-ratio transaction per clock while the output is not stalled and
// returns one result per transaction. The path runs through the 16 rotation cells of
// the tangent and the 32 quotient bit cells that run the four divisions side by side.
// Stages hold their items on output stall and empty stages keep taking input, so a
// waiting result does not stop the input until the pipeline is full. The near and far
// planes are read deep in the pipeline, so the user must make configuration writes
// only while no transaction is in flight; the block itself does not enforce this.
module perspective_projection_setup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_aspect_ratio,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_x_scale,
    output logic [31:0] o_y_scale,
    output logic [31:0] o_depth_scale,
    output logic signed [31:0] o_depth_offset,
    output logic        o_setup_error
);
    import ppsetup_pkg::*;

    logic [15:0] r_fov;
    logic [31:0] r_near;
    logic [31:0] r_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov  <= FOV_RESET;
            r_near <= NEAR_RESET;
            r_far  <= FAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOV:  r_fov  <= i_cfg_data[15:0];
                CFG_NEAR: r_near <= i_cfg_data;
                CFG_FAR:  r_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // angle setup
    logic        r_s0_valid;
    t_cordic     r_s0;
    t_cordic     n_s0;
    logic        s0_ready;
    logic [15:0] fov_c;
    logic [40:0] angle;

    logic    c_v [CORDIC_STAGES+1];
    logic    c_r [CORDIC_STAGES+1];
    t_cordic c_d [CORDIC_STAGES+1];

    always_comb begin
        fov_c = r_fov;
        if (r_fov < FOV_MIN) begin
            fov_c = FOV_MIN;
        end else if (r_fov > FOV_MAX) begin
            fov_c = FOV_MAX;
        end
        angle = 41'(fov_c) * 41'(RAD_PER_DEG) + 41'd256;
        n_s0.x = 34'sd1 <<< 30;
        n_s0.y = '0;
        n_s0.z = {2'b00, angle[40:9]};
        n_s0.aspect = i_aspect_ratio;
    end

    assign s0_ready = !r_s0_valid || c_r[0];
    assign o_stall  = !s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready) begin
            r_s0 <= n_s0;
        end
    end

    assign c_v[0] = r_s0_valid;
    assign c_d[0] = r_s0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ppsetup_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(g)),
            .i_valid (c_v[g]),
            .i_data  (c_d[g]),
            .i_ready (c_r[g+1]),
            .o_ready (c_r[g]),
            .o_valid (c_v[g+1]),
            .o_data  (c_d[g+1])
        );
    end

    // products
    logic  r_m_valid;
    t_mul  r_m;
    t_mul  n_m;
    logic  m_ready;
    logic  p_ready;

    always_comb begin
        n_m.ux = c_d[CORDIC_STAGES].x[33] ? '0 : c_d[CORDIC_STAGES].x[30:0];
        n_m.uy = (c_d[CORDIC_STAGES].y < 34'sd1) ? 31'd1 : c_d[CORDIC_STAGES].y[30:0];
        n_m.aspect = c_d[CORDIC_STAGES].aspect;
        n_m.p_auy  = 55'(n_m.aspect) * 55'(n_m.uy);
        n_m.p_aux  = 55'(n_m.aspect) * 55'(n_m.ux);
        n_m.p_fn   = 64'(r_far) * 64'(r_near);
    end

    assign m_ready = !r_m_valid || p_ready;
    assign c_r[CORDIC_STAGES] = m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= c_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready) begin
            r_m <= n_m;
        end
    end

    // division setup
    logic        r_p_valid;
    t_div_item   r_p;
    t_div_item   n_p;
    logic        lt1;
    logic        fgt;
    logic [31:0] plane_gap;
    logic [63:0] num [DIV_LANES];
    logic [63:0] den [DIV_LANES];

    logic      d_v [DIV_STEPS+1];
    logic      d_r [DIV_STEPS+1];
    t_div_item d_d [DIV_STEPS+1];

    always_comb begin
        lt1  = (r_m.aspect[23:16] == 8'd0);
        fgt  = r_far > r_near;
        plane_gap = fgt ? (r_far - r_near) : 32'd1;
        num[LANE_XS] = lt1 ? {17'd0, r_m.ux, 16'd0} : {1'b0, r_m.ux, 32'd0};
        den[LANE_XS] = lt1 ? 64'(r_m.uy) : 64'(r_m.p_auy);
        num[LANE_YS] = lt1 ? 64'(r_m.p_aux) : {17'd0, r_m.ux, 16'd0};
        den[LANE_YS] = 64'(r_m.uy);
        num[LANE_DS] = {16'd0, r_far, 16'd0};
        den[LANE_DS] = 64'(plane_gap);
        num[LANE_DO] = r_m.p_fn;
        den[LANE_DO] = 64'(plane_gap);
        for (int k = 0; k < DIV_LANES; k++) begin
            n_p.lane[k].rem = {32'd0, num[k][63:32]};
            n_p.lane[k].den = den[k];
            n_p.lane[k].nq  = num[k][31:0];
            n_p.lane[k].ov  = {32'd0, num[k][63:32]} >= den[k];
        end
        n_p.err = (r_m.aspect == 24'd0) || !fgt;
        n_p.fgt = fgt;
    end

    assign p_ready = !r_p_valid || d_r[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_ready) begin
            r_p_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready) begin
            r_p <= n_p;
        end
    end

    assign d_v[0] = r_p_valid;
    assign d_d[0] = r_p;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        ppsetup_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_v[g]),
            .i_data  (d_d[g]),
            .i_ready (d_r[g+1]),
            .o_ready (d_r[g]),
            .o_valid (d_v[g+1]),
            .o_data  (d_d[g+1])
        );
    end

    // result register
    logic        r_o_valid;
    logic [31:0] r_xs;
    logic [31:0] r_ys;
    logic [31:0] r_ds;
    logic [31:0] r_do;
    logic        r_err;
    logic [31:0] n_xs;
    logic [31:0] n_ys;
    logic [31:0] n_ds;
    logic [31:0] n_do;
    logic [31:0] q_do;
    logic        o_ready;
    t_div_item   fin;

    assign fin     = d_d[DIV_STEPS];
    assign o_ready = !r_o_valid || !i_stall;
    assign d_r[DIV_STEPS] = o_ready;

    always_comb begin
        n_xs = fin.lane[LANE_XS].ov ? '1 : fin.lane[LANE_XS].nq;
        n_ys = fin.lane[LANE_YS].ov ? '1 : fin.lane[LANE_YS].nq;
        n_ds = (fin.lane[LANE_DS].ov || !fin.fgt) ? '1 : fin.lane[LANE_DS].nq;
        q_do = fin.lane[LANE_DO].ov ? '1 : fin.lane[LANE_DO].nq;
        if (q_do > 32'h8000_0000) begin
            q_do = 32'h8000_0000;
        end
        n_do = fin.fgt ? (32'd0 - q_do) : 32'h8000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready) begin
            r_o_valid <= d_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_xs  <= n_xs;
            r_ys  <= n_ys;
            r_ds  <= n_ds;
            r_do  <= n_do;
            r_err <= fin.err;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_x_scale      = r_xs;
    assign o_y_scale      = r_ys;
    assign o_depth_scale  = r_ds;
    assign o_depth_offset = r_do;
    assign o_setup_error  = r_err;

endmodule

### sv/ppsetup_checker.sv
// port-level checks for the perspective projection setup block
module ppsetup_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_x_scale,
    input logic [31:0] o_depth_scale,
    input logic signed [31:0] o_depth_offset,
    input logic        o_setup_error
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_scale) && $stable(o_depth_offset))
        else $error("stalled transaction changed");

    a_offset_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_depth_offset[31] || (o_depth_offset == 32'sd0))
        else $error("depth offset positive");

    a_depth_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_setup_error |-> o_depth_scale >= 32'h0001_0000)
        else $error("depth scale below one");

endmodule

bind perspective_projection_setup ppsetup_checker u_ppsetup_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_x_scale      (o_x_scale),
    .o_depth_scale  (o_depth_scale),
    .o_depth_offset (o_depth_offset),
    .o_setup_error  (o_setup_error)
);
